### hw/rtl/clkcal_pkg.sv
// ----------------------------------------------------------------------------
// Clock calendar package
// Shared types, constants and digit helpers for the clock calendar block.
// ----------------------------------------------------------------------------
package clkcal_pkg;

  typedef enum logic [1:0] {
    MODE_TIME     = 2'd0,
    MODE_DATE     = 2'd1,
    MODE_SET_TIME = 2'd2,
    MODE_SET_DATE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_SECOND_DIVIDE_LAST = 2'd0,
    CFG_BLINK_LAST         = 2'd1,
    CFG_DOT_OFF_AT         = 2'd2,
    CFG_FIELD_OFF_AT       = 2'd3
  } cfg_index_t;

  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] SECOND_DIVIDE_LAST_RST = 16'd199;
  localparam logic [7:0]  BLINK_LAST_RST         = 8'd199;
  localparam logic [7:0]  DOT_OFF_AT_RST         = 8'd50;
  localparam logic [7:0]  FIELD_OFF_AT_RST       = 8'd100;

  localparam logic [5:0] SEC_RST  = 6'd50;
  localparam logic [5:0] MIN_RST  = 6'd59;
  localparam logic [4:0] HOUR_RST = 5'd23;
  localparam logic [4:0] DAY_RST  = 5'd1;
  localparam logic [3:0] MON_RST  = 4'd1;
  localparam logic [6:0] YEAR_RST = 7'd18;

  localparam logic [5:0] SEC_LAST  = 6'd59;
  localparam logic [5:0] MIN_LAST  = 6'd59;
  localparam logic [4:0] HOUR_LAST = 5'd23;
  localparam logic [3:0] MON_LAST  = 4'd12;
  localparam logic [6:0] YEAR_LAST = 7'd99;

  // Date edit fields; the unused code behaves as the year field.
  localparam logic [1:0] DFIELD_DAY  = 2'd0;
  localparam logic [1:0] DFIELD_MON  = 2'd1;
  localparam logic [1:0] DFIELD_YEAR = 2'd2;

  localparam logic [7:0] SEG_BLANK = 8'h00;

  typedef struct packed {
    mode_t      mode;
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] mon;
    logic [6:0] year;
    logic       tfield;
    logic [1:0] dfield;
    logic       lit;
  } disp_state_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] len;
    case (mon) inside
      4'd2:                   len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

  // Segment pattern, gfedcba in bits 6..0, dot in bit 7.
  function automatic logic [7:0] seg_encode(input logic [3:0] v, input logic dot);
    logic [6:0] p;
    case (v)
      4'd0:    p = 7'h3F;
      4'd1:    p = 7'h06;
      4'd2:    p = 7'h5B;
      4'd3:    p = 7'h4F;
      4'd4:    p = 7'h66;
      4'd5:    p = 7'h6D;
      4'd6:    p = 7'h7D;
      4'd7:    p = 7'h07;
      4'd8:    p = 7'h7F;
      4'd9:    p = 7'h6F;
      default: p = 7'h00;
    endcase
    return {dot, p};
  endfunction

  // Tens and ones of a 7-bit value; tens is v*205 >> 11, exact below 128.
  function automatic logic [7:0] split_digits(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

  function automatic logic [15:0] two_digits(input logic [6:0] v, input logic dot);
    logic [7:0] td;
    td = split_digits(v);
    return {seg_encode(td[7:4], 1'b0), seg_encode(td[3:0], dot)};
  endfunction

endpackage

### hw/rtl/clkcal_if.sv
// ----------------------------------------------------------------------------
// Clock calendar channels
// Valid/ready channels for key samples and for display results.
// ----------------------------------------------------------------------------
interface clkcal_in_if;
  logic valid;
  logic ready;
  logic key_set;
  logic key_mode;

  modport source (output valid, output key_set, output key_mode, input ready);
  modport sink   (input valid, input key_set, input key_mode, output ready);
endinterface

interface clkcal_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] digit_seg_1;
  logic [7:0] digit_seg_2;
  logic [7:0] digit_seg_3;
  logic [7:0] digit_seg_4;
  logic [7:0] digit_seg_5;
  logic [7:0] digit_seg_6;
  logic [1:0] view_mode;

  modport source (output valid, output digit_seg_1, output digit_seg_2, output digit_seg_3,
                  output digit_seg_4, output digit_seg_5, output digit_seg_6,
                  output view_mode, input ready);
  modport sink   (input valid, input digit_seg_1, input digit_seg_2, input digit_seg_3,
                  input digit_seg_4, input digit_seg_5, input digit_seg_6,
                  input view_mode, output ready);
endinterface

### hw/rtl/clkcal_disp.sv
// ----------------------------------------------------------------------------
// Clock calendar display encoder
// Turns the clock state into six seven-segment patterns for the current mode.
// ----------------------------------------------------------------------------
module clkcal_disp
  import clkcal_pkg::*;
(
  input  disp_state_t      st,
  output logic [5:0][7:0]  digits
);

  logic [15:0] sec_seg, min_seg, hour_seg;
  logic [15:0] day_seg, mon_seg, year_seg;
  logic [15:0] sec_dot_seg, min_dot_seg, hour_dot_seg;
  logic        full;

  assign full = st.lit;

  always_comb begin
    sec_seg      = two_digits(7'(st.sec), 1'b0);
    min_seg      = two_digits(7'(st.min), 1'b0);
    hour_seg     = two_digits(7'(st.hour), 1'b0);
    sec_dot_seg  = two_digits(7'(st.sec), st.lit);
    min_dot_seg  = two_digits(7'(st.min), st.lit);
    hour_dot_seg = two_digits(7'(st.hour), st.lit);
    day_seg      = two_digits(7'(st.day), 1'b1);
    mon_seg      = two_digits(7'(st.mon), 1'b1);
    year_seg     = two_digits(st.year, 1'b0);

    digits = '{default: SEG_BLANK};
    case (st.mode)
      MODE_TIME: begin
        {digits[1], digits[0]} = sec_dot_seg;
        {digits[3], digits[2]} = min_dot_seg;
        {digits[5], digits[4]} = hour_dot_seg;
      end
      MODE_DATE: begin
        {digits[1], digits[0]} = year_seg;
        {digits[3], digits[2]} = mon_seg;
        {digits[5], digits[4]} = day_seg;
      end
      MODE_SET_TIME: begin
        // Off phase of the blink shows only the field being edited.
        if (full) begin
          {digits[1], digits[0]} = sec_seg;
        end
        if (full || st.tfield) begin
          {digits[3], digits[2]} = min_seg;
        end
        if (full || !st.tfield) begin
          {digits[5], digits[4]} = hour_seg;
        end
      end
      default: begin
        if (full || st.dfield >= DFIELD_YEAR) begin
          {digits[1], digits[0]} = year_seg;
        end
        if (full || st.dfield == DFIELD_MON) begin
          {digits[3], digits[2]} = mon_seg;
        end
        if (full || st.dfield == DFIELD_DAY) begin
          {digits[5], digits[4]} = day_seg;
        end
      end
    endcase
  end

endmodule

### hw/rtl/clock_calendar_seven_segment_top.sv
// ----------------------------------------------------------------------------
// Clock calendar with seven-segment output
// Digital clock and calendar that advances one tick per transaction.
// ----------------------------------------------------------------------------
// Each input transaction is one tick carrying the set and mode key levels; it
// produces exactly one output transaction with six segment patterns and the
// view mode after the tick. A tick can be accepted every clock cycle while the
// output side keeps up: the clock state and the output register both load at
// the accepting edge, so throughput is one tick per cycle. Input ready drops
// only while a result is waiting and the output side is stalled. Configuration
// writes take effect at the next edge.
module clock_calendar_seven_segment_top
  import clkcal_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  clkcal_in_if.sink             in_ch,
  clkcal_out_if.source          out_ch,
  input  logic                  cfg_we,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [15:0] sec_last_r;
  logic [7:0]  blink_last_r, dot_off_r, field_off_r;

  // Clock state
  logic [15:0] presc_r, presc_nxt;
  logic [5:0]  sec_r, sec_nxt, min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt, day_r, day_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [6:0]  year_r, year_nxt;
  mode_t       mode_r, mode_nxt;
  logic        tfield_r, tfield_nxt;
  logic [1:0]  dfield_r, dfield_nxt;
  logic        set_seen_r, mode_seen_r;
  logic [7:0]  dot_cnt_r, dot_cnt_nxt, edit_cnt_r, edit_cnt_nxt;
  logic        lit_r, lit_nxt;

  // Output register
  logic            out_valid_r;
  logic [5:0][7:0] seg_r;
  logic [1:0]      view_r;

  logic            accept;
  logic            set_press, mode_press;
  disp_state_t     disp_st;
  logic [5:0][7:0] digits;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign set_press   = in_ch.key_set && !set_seen_r;
  assign mode_press  = in_ch.key_mode && !mode_seen_r;

  always_comb begin
    presc_nxt    = presc_r;
    sec_nxt      = sec_r;
    min_nxt      = min_r;
    hour_nxt     = hour_r;
    day_nxt      = day_r;
    mon_nxt      = mon_r;
    year_nxt     = year_r;
    mode_nxt     = mode_r;
    tfield_nxt   = tfield_r;
    dfield_nxt   = dfield_r;
    dot_cnt_nxt  = dot_cnt_r;
    edit_cnt_nxt = edit_cnt_r;
    lit_nxt      = lit_r;

    // Set key: toggle view, or bump the field under edit.
    if (set_press) begin
      case (mode_r)
        MODE_TIME: mode_nxt = MODE_DATE;
        MODE_DATE: mode_nxt = MODE_TIME;
        MODE_SET_TIME: begin
          if (!tfield_r) begin
            hour_nxt = (hour_r >= HOUR_LAST) ? 5'd0 : hour_r + 5'd1;
          end else begin
            min_nxt = (min_r >= MIN_LAST) ? 6'd0 : min_r + 6'd1;
          end
        end
        default: begin
          if (dfield_r == DFIELD_DAY) begin
            day_nxt = (day_r >= month_len(mon_r)) ? 5'd1 : day_r + 5'd1;
          end else if (dfield_r == DFIELD_MON) begin
            mon_nxt = (mon_r >= MON_LAST) ? 4'd1 : mon_r + 4'd1;
          end else begin
            year_nxt = (year_r >= YEAR_LAST) ? 7'd0 : year_r + 7'd1;
          end
        end
      endcase
    end

    // Mode key acts on the mode left by the set key.
    if (mode_press) begin
      case (mode_nxt)
        MODE_TIME: mode_nxt = MODE_SET_TIME;
        MODE_DATE: mode_nxt = MODE_SET_DATE;
        MODE_SET_TIME: begin
          if (!tfield_r) begin
            tfield_nxt = 1'b1;
          end else begin
            tfield_nxt = 1'b0;
            mode_nxt   = MODE_TIME;
          end
        end
        default: begin
          if (dfield_r == DFIELD_DAY) begin
            dfield_nxt = DFIELD_MON;
          end else if (dfield_r == DFIELD_MON) begin
            dfield_nxt = DFIELD_YEAR;
          end else begin
            dfield_nxt = DFIELD_DAY;
            mode_nxt   = MODE_DATE;
          end
        end
      endcase
    end

    // Timekeeping runs only in the two view modes.
    if (mode_nxt == MODE_TIME || mode_nxt == MODE_DATE) begin
      if (presc_r == sec_last_r) begin
        presc_nxt = 16'd0;
        if (sec_nxt >= SEC_LAST) begin
          sec_nxt = 6'd0;
          if (min_nxt >= MIN_LAST) begin
            min_nxt = 6'd0;
            if (hour_nxt >= HOUR_LAST) begin
              hour_nxt = 5'd0;
              if (day_nxt >= month_len(mon_nxt)) begin
                day_nxt = 5'd1;
                if (mon_nxt >= MON_LAST) begin
                  mon_nxt  = 4'd1;
                  year_nxt = (year_nxt >= YEAR_LAST) ? 7'd0 : year_nxt + 7'd1;
                end else begin
                  mon_nxt = mon_nxt + 4'd1;
                end
              end else begin
                day_nxt = day_nxt + 5'd1;
              end
            end else begin
              hour_nxt = hour_nxt + 5'd1;
            end
          end else begin
            min_nxt = min_nxt + 6'd1;
          end
        end else begin
          sec_nxt = sec_nxt + 6'd1;
        end
      end else begin
        presc_nxt = presc_r + 16'd1;
      end
    end

    // Blink counters.
    case (mode_nxt)
      MODE_TIME: begin
        if (dot_cnt_r == 8'd1) begin
          lit_nxt = 1'b1;
          dot_cnt_nxt = dot_cnt_r + 8'd1;
        end else if (dot_cnt_r == dot_off_r) begin
          lit_nxt = 1'b0;
          dot_cnt_nxt = dot_cnt_r + 8'd1;
        end else if (dot_cnt_r == blink_last_r) begin
          // Restart lands on one, not on zero.
          dot_cnt_nxt = 8'd1;
        end else begin
          dot_cnt_nxt = dot_cnt_r + 8'd1;
        end
      end
      MODE_SET_TIME, MODE_SET_DATE: begin
        if (edit_cnt_r == 8'd1) begin
          lit_nxt = 1'b1;
          edit_cnt_nxt = edit_cnt_r + 8'd1;
        end else if (edit_cnt_r == field_off_r) begin
          lit_nxt = 1'b0;
          edit_cnt_nxt = edit_cnt_r + 8'd1;
        end else if (edit_cnt_r == blink_last_r) begin
          edit_cnt_nxt = 8'd0;
        end else begin
          edit_cnt_nxt = edit_cnt_r + 8'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign disp_st = '{mode: mode_nxt, sec: sec_nxt, min: min_nxt, hour: hour_nxt,
                     day: day_nxt, mon: mon_nxt, year: year_nxt, tfield: tfield_nxt,
                     dfield: dfield_nxt, lit: lit_nxt};

  clkcal_disp u_disp (
    .st     (disp_st),
    .digits (digits)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_last_r   <= SECOND_DIVIDE_LAST_RST;
      blink_last_r <= BLINK_LAST_RST;
      dot_off_r    <= DOT_OFF_AT_RST;
      field_off_r  <= FIELD_OFF_AT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SECOND_DIVIDE_LAST: sec_last_r   <= cfg_wdata[15:0];
        CFG_BLINK_LAST:         blink_last_r <= cfg_wdata[7:0];
        CFG_DOT_OFF_AT:         dot_off_r    <= cfg_wdata[7:0];
        CFG_FIELD_OFF_AT:       field_off_r  <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presc_r     <= 16'd0;
      sec_r       <= SEC_RST;
      min_r       <= MIN_RST;
      hour_r      <= HOUR_RST;
      day_r       <= DAY_RST;
      mon_r       <= MON_RST;
      year_r      <= YEAR_RST;
      mode_r      <= MODE_TIME;
      tfield_r    <= 1'b0;
      dfield_r    <= DFIELD_DAY;
      set_seen_r  <= 1'b0;
      mode_seen_r <= 1'b0;
      dot_cnt_r   <= 8'd0;
      edit_cnt_r  <= 8'd0;
      lit_r       <= 1'b0;
    end else if (accept) begin
      presc_r     <= presc_nxt;
      sec_r       <= sec_nxt;
      min_r       <= min_nxt;
      hour_r      <= hour_nxt;
      day_r       <= day_nxt;
      mon_r       <= mon_nxt;
      year_r      <= year_nxt;
      mode_r      <= mode_nxt;
      tfield_r    <= tfield_nxt;
      dfield_r    <= dfield_nxt;
      set_seen_r  <= in_ch.key_set;
      mode_seen_r <= in_ch.key_mode;
      dot_cnt_r   <= dot_cnt_nxt;
      edit_cnt_r  <= edit_cnt_nxt;
      lit_r       <= lit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seg_r  <= digits;
      view_r <= mode_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.digit_seg_1 = seg_r[0];
  assign out_ch.digit_seg_2 = seg_r[1];
  assign out_ch.digit_seg_3 = seg_r[2];
  assign out_ch.digit_seg_4 = seg_r[3];
  assign out_ch.digit_seg_5 = seg_r[4];
  assign out_ch.digit_seg_6 = seg_r[5];
  assign out_ch.view_mode   = view_r;

endmodule

### hw/rtl/clkcal_chk.sv
// ----------------------------------------------------------------------------
// Clock calendar port checker
// Concurrent assertions on the top-level ports, attached by bind.
// ----------------------------------------------------------------------------
module clkcal_chk
  import clkcal_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] seg_2,
  input logic [7:0] seg_3,
  input logic [7:0] seg_4,
  input logic [7:0] seg_5,
  input logic [7:0] seg_6,
  input logic [1:0] view_mode
);

  // A stalled result keeps its mode until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(view_mode))
    else $error("output transaction changed while stalled");

  // With the output register empty, the block must take a tick.
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready with empty output register");

  // Every accepted tick yields a result on the next cycle.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transaction produced no result");

  // Time view lights dots only on the ones digits.
  a_time_dots: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && view_mode == MODE_TIME |-> !seg_2[7] && !seg_4[7] && !seg_6[7])
    else $error("dot on a tens digit in time view");

  // Date view always shows the day and month separators.
  a_date_dots: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && view_mode == MODE_DATE |-> seg_3[7] && seg_5[7])
    else $error("date separators missing in date view");

endmodule

bind clock_calendar_seven_segment_top clkcal_chk u_clkcal_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .seg_2     (out_ch.digit_seg_2),
  .seg_3     (out_ch.digit_seg_3),
  .seg_4     (out_ch.digit_seg_4),
  .seg_5     (out_ch.digit_seg_5),
  .seg_6     (out_ch.digit_seg_6),
  .view_mode (out_ch.view_mode)
);

### dv/clock_calendar_seven_segment_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock calendar seven-segment testbench
// Sends key ticks through the input channel under several register settings
// and idle patterns. Each tick is run through a local model of the clock,
// calendar, mode keys and blink logic, and every display transaction is
// compared digit by digit with the oldest predicted display.
// ----------------------------------------------------------------------------
module clock_calendar_seven_segment_top_test;
  import clkcal_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [5:0][7:0] seg;
    mode_t           view;
  } display_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_index_t            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  clkcal_in_if  in_ch ();
  clkcal_out_if out_ch ();

  clock_calendar_seven_segment_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Local copy of the block's registers and state.
  logic [15:0] sec_last_tick;
  logic [7:0]  blink_wrap, dot_dark_at, blank_at;
  logic [15:0] prescale;
  logic [5:0]  now_sec, now_min;
  logic [4:0]  now_hour, cal_day;
  logic [3:0]  cal_mon;
  logic [6:0]  cal_year;
  mode_t       disp_mode;
  logic        time_fld;
  logic [1:0]  date_fld;
  logic        set_held, mode_held;
  logic [7:0]  dot_cnt, edit_cnt;
  logic        lit;

  display_t pending_displays[$];
  display_t seen_disp, want_disp;
  int       items_sent;
  int       mismatches;
  int       quiet_cycles;
  int       in_idle_pct;
  int       out_stall_pct;

  function automatic void reset_model();
    sec_last_tick = SECOND_DIVIDE_LAST_RST;
    blink_wrap    = BLINK_LAST_RST;
    dot_dark_at   = DOT_OFF_AT_RST;
    blank_at      = FIELD_OFF_AT_RST;
    prescale      = 16'd0;
    now_sec       = SEC_RST;
    now_min       = MIN_RST;
    now_hour      = HOUR_RST;
    cal_day       = DAY_RST;
    cal_mon       = MON_RST;
    cal_year      = YEAR_RST;
    disp_mode     = MODE_TIME;
    time_fld      = 1'b0;
    date_fld      = DFIELD_DAY;
    set_held      = 1'b0;
    mode_held     = 1'b0;
    dot_cnt       = 8'd0;
    edit_cnt      = 8'd0;
    lit           = 1'b0;
  endfunction

  function automatic logic [7:0] seg_pattern(input int v, input logic dot);
    logic [6:0] p;
    case (v)
      0:       p = 7'h3F;
      1:       p = 7'h06;
      2:       p = 7'h5B;
      3:       p = 7'h4F;
      4:       p = 7'h66;
      5:       p = 7'h6D;
      6:       p = 7'h7D;
      7:       p = 7'h07;
      8:       p = 7'h7F;
      9:       p = 7'h6F;
      default: p = 7'h00;
    endcase
    return {dot, p};
  endfunction

  // Tens digit in the upper byte, ones digit (with its dot) in the lower.
  function automatic logic [15:0] two_digit(input int v, input logic dot);
    return {seg_pattern(v / 10, 1'b0), seg_pattern(v % 10, dot)};
  endfunction

  function automatic logic [4:0] days_in_month();
    case (cal_mon)
      4'd2:                    return 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default:                 return 5'd31;
    endcase
  endfunction

  function automatic void roll_day();
    if (cal_day >= days_in_month()) begin
      cal_day = 5'd1;
      if (cal_mon >= MON_LAST) begin
        cal_mon  = 4'd1;
        cal_year = (cal_year >= YEAR_LAST) ? 7'd0 : cal_year + 7'd1;
      end else begin
        cal_mon = cal_mon + 4'd1;
      end
    end else begin
      cal_day = cal_day + 5'd1;
    end
  endfunction

  function automatic void count_time();
    if (prescale == sec_last_tick) begin
      prescale = 16'd0;
      if (now_sec >= SEC_LAST) begin
        now_sec = 6'd0;
        if (now_min >= MIN_LAST) begin
          now_min = 6'd0;
          if (now_hour >= HOUR_LAST) begin
            now_hour = 5'd0;
            roll_day();
          end else begin
            now_hour = now_hour + 5'd1;
          end
        end else begin
          now_min = now_min + 6'd1;
        end
      end else begin
        now_sec = now_sec + 6'd1;
      end
    end else begin
      prescale = prescale + 16'd1;
    end
  endfunction

  function automatic void bump_field();
    if (disp_mode == MODE_SET_TIME) begin
      if (!time_fld) now_hour = (now_hour >= HOUR_LAST) ? 5'd0 : now_hour + 5'd1;
      else now_min = (now_min >= MIN_LAST) ? 6'd0 : now_min + 6'd1;
    end else if (date_fld == DFIELD_DAY) begin
      cal_day = (cal_day >= days_in_month()) ? 5'd1 : cal_day + 5'd1;
    end else if (date_fld == DFIELD_MON) begin
      cal_mon = (cal_mon >= MON_LAST) ? 4'd1 : cal_mon + 4'd1;
    end else begin
      cal_year = (cal_year >= YEAR_LAST) ? 7'd0 : cal_year + 7'd1;
    end
  endfunction

  function automatic void next_mode();
    case (disp_mode)
      MODE_TIME: disp_mode = MODE_SET_TIME;
      MODE_DATE: disp_mode = MODE_SET_DATE;
      MODE_SET_TIME: begin
        if (!time_fld) begin
          time_fld = 1'b1;
        end else begin
          time_fld  = 1'b0;
          disp_mode = MODE_TIME;
        end
      end
      default: begin
        if (date_fld == DFIELD_DAY) begin
          date_fld = DFIELD_MON;
        end else if (date_fld == DFIELD_MON) begin
          date_fld = DFIELD_YEAR;
        end else begin
          date_fld  = DFIELD_DAY;
          disp_mode = MODE_DATE;
        end
      end
    endcase
  endfunction

  function automatic void edit_blink_step();
    if (edit_cnt == 8'd1) begin
      lit      = 1'b1;
      edit_cnt = edit_cnt + 8'd1;
    end else if (edit_cnt == blank_at) begin
      lit      = 1'b0;
      edit_cnt = edit_cnt + 8'd1;
    end else if (edit_cnt == blink_wrap) begin
      edit_cnt = 8'd0;
    end else begin
      edit_cnt = edit_cnt + 8'd1;
    end
  endfunction

  // Advances the local state by one tick and returns the display it yields.
  function automatic display_t advance_tick(input logic ks, input logic km);
    display_t r;
    logic     full;
    r.seg = '0;
    if (ks && !set_held) begin
      case (disp_mode)
        MODE_TIME: disp_mode = MODE_DATE;
        MODE_DATE: disp_mode = MODE_TIME;
        default:   bump_field();
      endcase
    end
    set_held = ks;
    if (km && !mode_held) next_mode();
    mode_held = km;

    case (disp_mode)
      MODE_TIME: begin
        count_time();
        // The restart test only runs when neither dot test matched.
        if (dot_cnt == 8'd1) lit = 1'b1;
        else if (dot_cnt == dot_dark_at) lit = 1'b0;
        else if (dot_cnt == blink_wrap) dot_cnt = 8'd0;
        dot_cnt = dot_cnt + 8'd1;
        r.seg[1:0] = two_digit(now_sec, lit);
        r.seg[3:2] = two_digit(now_min, lit);
        r.seg[5:4] = two_digit(now_hour, lit);
      end
      MODE_DATE: begin
        count_time();
        r.seg[1:0] = two_digit(cal_year, 1'b0);
        r.seg[3:2] = two_digit(cal_mon, 1'b1);
        r.seg[5:4] = two_digit(cal_day, 1'b1);
      end
      MODE_SET_TIME: begin
        edit_blink_step();
        full = lit;
        if (full || time_fld) r.seg[3:2] = two_digit(now_min, 1'b0);
        if (full || !time_fld) r.seg[5:4] = two_digit(now_hour, 1'b0);
        if (full) r.seg[1:0] = two_digit(now_sec, 1'b0);
      end
      default: begin
        edit_blink_step();
        full = lit;
        if (full || date_fld >= DFIELD_YEAR) r.seg[1:0] = two_digit(cal_year, 1'b0);
        if (full || date_fld == DFIELD_MON) r.seg[3:2] = two_digit(cal_mon, 1'b1);
        if (full || date_fld == DFIELD_DAY) r.seg[5:4] = two_digit(cal_day, 1'b1);
      end
    endcase
    r.view = disp_mode;
    return r;
  endfunction

  function automatic int selected_value();
    if (disp_mode == MODE_SET_TIME) return time_fld ? int'(now_min) : int'(now_hour);
    case (date_fld)
      DFIELD_DAY: return cal_day;
      DFIELD_MON: return cal_mon;
      default:    return cal_year;
    endcase
  endfunction

  function automatic void log_mismatch(input string what, input logic [7:0] exp_v,
                                       input logic [7:0] act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, exp_v, act_v);
  endfunction

  // Display checker.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_disp.seg[0] = out_ch.digit_seg_1;
      seen_disp.seg[1] = out_ch.digit_seg_2;
      seen_disp.seg[2] = out_ch.digit_seg_3;
      seen_disp.seg[3] = out_ch.digit_seg_4;
      seen_disp.seg[4] = out_ch.digit_seg_5;
      seen_disp.seg[5] = out_ch.digit_seg_6;
      seen_disp.view   = mode_t'(out_ch.view_mode);
      if (pending_displays.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: display transaction with none expected", $time);
      end else begin
        want_disp = pending_displays.pop_front();
        for (int i = 0; i < 6; i++) begin
          if (seen_disp.seg[i] !== want_disp.seg[i])
            log_mismatch($sformatf("digit_seg_%0d", i + 1), want_disp.seg[i], seen_disp.seg[i]);
        end
        if (seen_disp.view !== want_disp.view)
          log_mismatch("view_mode", 8'(want_disp.view), 8'(seen_disp.view));
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_tick(input logic ks, input logic km);
    while ($urandom_range(99) < in_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.key_set  <= ks;
    in_ch.key_mode <= km;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    pending_displays.push_back(advance_tick(ks, km));
    items_sent++;
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_tick(1'b0, 1'b0);
  endtask

  // One key press: held for a few ticks, then released.
  task automatic tap(input logic ks, input logic km, input logic quick);
    int hold, rel;
    hold = quick ? 1 : $urandom_range(1, 3);
    rel  = quick ? 1 : $urandom_range(1, 2);
    repeat (hold) send_tick(ks, km);
    run_ticks(rel);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_displays.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    case (idx)
      CFG_SECOND_DIVIDE_LAST: sec_last_tick = 16'(value);
      CFG_BLINK_LAST:         blink_wrap    = 8'(value);
      CFG_DOT_OFF_AT:         dot_dark_at   = 8'(value);
      default:                blank_at      = 8'(value);
    endcase
  endtask

  task automatic set_config(input int sdl, input int bl, input int dot, input int fld);
    drain();
    write_reg(CFG_SECOND_DIVIDE_LAST, sdl);
    write_reg(CFG_BLINK_LAST, bl);
    write_reg(CFG_DOT_OFF_AT, dot);
    write_reg(CFG_FIELD_OFF_AT, fld);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Steps the selected edit field, mostly toward its last or first value.
  task automatic tune_field();
    int lo, hi, target, guard, pick;
    guard = 0;
    if (disp_mode == MODE_SET_TIME) begin
      lo = 0;
      hi = time_fld ? 59 : 23;
    end else begin
      case (date_fld)
        DFIELD_DAY: begin lo = 1; hi = days_in_month(); end
        DFIELD_MON: begin lo = 1; hi = 12; end
        default:    begin lo = 0; hi = 99; end
      endcase
    end
    pick = $urandom_range(99);
    if (pick < 40) target = hi;
    else if (pick < 55) target = lo;
    else if (pick < 85) target = $urandom_range(hi, lo);
    else target = -1;
    if (target < 0) begin
      repeat ($urandom_range(3)) tap(1'b1, 1'b0, 1'b0);
    end else begin
      while (selected_value() != target && guard <= hi) begin
        tap(1'b1, 1'b0, 1'b1);
        guard++;
      end
    end
  endtask

  task automatic edit_session();
    int steps;
    steps = 0;
    if (disp_mode == MODE_TIME || disp_mode == MODE_DATE) begin
      if ($urandom_range(1)) tap(1'b1, 1'b0, 1'b0);
      tap(1'b0, 1'b1, 1'b0);
    end
    while ((disp_mode == MODE_SET_TIME || disp_mode == MODE_SET_DATE) && steps < 4) begin
      tune_field();
      tap(1'b0, 1'b1, 1'b0);
      steps++;
    end
  endtask

  task automatic random_session(input int budget);
    int stop, pick;
    stop = items_sent + budget;
    while (items_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        edit_session();
      end else if (pick < 60) begin
        run_ticks($urandom_range(1, 120));
      end else if (pick < 72) begin
        tap(1'b1, 1'b0, 1'b0);
      end else if (pick < 80) begin
        tap(1'b0, 1'b1, 1'b0);
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 12))
          send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        drain();
      end
    end
  endtask

  // Midnight rollover from the reset time, then every view and edit transition.
  task automatic test_directed();
    set_config(1, 4, 2, 3);
    run_ticks(20);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
  endtask

  task automatic test_fastest_rates();
    set_config(1, 2, 1, 1);
    in_idle_pct   = 0;
    out_stall_pct = 0;
    random_session(150);
  endtask

  task automatic test_sender_gaps();
    int bl;
    bl = $urandom_range(3, 60);
    set_config($urandom_range(1, 3), bl, $urandom_range(1, bl), $urandom_range(1, bl));
    in_idle_pct   = 83;
    out_stall_pct = 0;
    random_session(150);
  endtask

  task automatic test_receiver_stalls();
    int bl;
    bl = $urandom_range(3, 60);
    set_config($urandom_range(3, 4), bl, $urandom_range(1, bl), $urandom_range(1, bl));
    in_idle_pct   = 0;
    out_stall_pct = 83;
    random_session(150);
  endtask

  task automatic test_widest_blink();
    set_config($urandom_range(4, 6), 255, 255, 255);
    in_idle_pct   = 13;
    out_stall_pct = 13;
    random_session(150);
  endtask

  // Lowering the blink limit leaves the counters above it for a while.
  task automatic test_reset_values();
    set_config(SECOND_DIVIDE_LAST_RST, BLINK_LAST_RST, DOT_OFF_AT_RST, FIELD_OFF_AT_RST);
    in_idle_pct   = 13;
    out_stall_pct = 0;
    random_session(100);
  endtask

  task automatic test_slowest_divider();
    set_config(65535, 2, 1, 2);
    in_idle_pct   = 0;
    out_stall_pct = 13;
    random_session(50);
  endtask

  // The prescaler is now beyond the new limit and has to wrap around.
  task automatic test_divider_overrun();
    set_config(2, $urandom_range(2, 255), $urandom_range(1, 255), $urandom_range(1, 255));
    in_idle_pct   = 13;
    out_stall_pct = 13;
    random_session(50);
  endtask

  initial begin
    reset_model();
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_SECOND_DIVIDE_LAST;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.key_set  = 1'b0;
    in_ch.key_mode = 1'b0;
    out_ch.ready   = 1'b0;
    in_idle_pct    = 0;
    out_stall_pct  = 0;
    items_sent     = 0;
    mismatches     = 0;
    quiet_cycles   = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fastest_rates();
    test_sender_gaps();
    test_receiver_stalls();
    test_widest_blink();
    test_reset_values();
    test_slowest_divider();
    test_divider_overrun();

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_displays.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
